@@ rtl/lpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lpsd_pkg: shared types, constants and pattern table
// Widths, codes and the constant LED pattern table of the sequencer.
// ----------------------------------------------------------------------------
package lpsd_pkg;

   localparam int LED_COUNT     = 20;
   localparam int INPUT_COUNT   = 3;
   localparam int MAX_STEPS     = 32;
   localparam int PATTERN_COUNT = 3;
   localparam int TICK_MS       = 5;

   typedef logic [LED_COUNT-1:0]   led_type;
   typedef logic [INPUT_COUNT-1:0] pins_type;
   typedef logic [1:0]             sel_type;
   typedef logic [7:0]             count_type;

   // command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // register indexes
   localparam logic [7:0] CSR_TICK_PRESCALE  = 8'd0;
   localparam logic [7:0] CSR_DEBOUNCE_TICKS = 8'd1;

   localparam count_type TICK_PRESCALE_RESET  = 8'd5;
   localparam count_type DEBOUNCE_TICKS_RESET = 8'd4;

   localparam sel_type   NO_PATTERN = 2'd3;
   localparam count_type DUR_LOOP   = 8'hFF;
   localparam count_type DUR_END    = 8'h00;

   // durations in updates
   localparam count_type DUR_5   = 8'(5 / TICK_MS);
   localparam count_type DUR_10  = 8'(10 / TICK_MS);
   localparam count_type DUR_20  = 8'(20 / TICK_MS);
   localparam count_type DUR_50  = 8'(50 / TICK_MS);
   localparam count_type DUR_250 = 8'(250 / TICK_MS);

   // one table entry: mask in the low bits, then duration, then buzzer flag
   typedef struct packed {
      logic      buz;
      count_type dur;
      led_type   mask;
   } rom_entry_type;

   // player controls for one item
   typedef struct packed {
      logic    tick;
      logic    start;
      logic    update;
      sel_type sel;
   } player_ctl_type;

   function automatic logic pattern_valid(input sel_type p);
      return 32'(p) < PATTERN_COUNT;
   endfunction

   // LED groups walked by the animations
   function automatic led_type group_mask(input logic [2:0] g);
      led_type m;
      m = '0;
      unique case (g)
         3'd0: m = led_type'(32'h0000_0007);
         3'd1: m = led_type'(32'h0000_0038);
         3'd2: m = led_type'(32'h0000_01C0);
         3'd3: m = led_type'(32'h0000_0E00);
         3'd4: m = led_type'(32'h0000_7000);
         3'd5: m = led_type'(32'h0003_8000);
         3'd6: m = led_type'(32'h000C_0000);
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic rom_entry_type make_entry(input logic [2:0] g, input logic use_group,
                                                input count_type dur, input logic buz);
      rom_entry_type e;
      e.mask = use_group ? group_mask(g) : '0;
      e.dur  = dur;
      e.buz  = buz;
      return e;
   endfunction

   // constant pattern table; out-of-range entries read as end entries
   function automatic rom_entry_type rom_read(input sel_type p, input count_type step);
      rom_entry_type e;
      e = '0;
      if (pattern_valid(p) && 32'(step) < MAX_STEPS) begin
         unique case (p)
            2'd0: begin
               unique case (step[4:0])
                  5'd0, 5'd7, 5'd14:  e = make_entry(3'd0, 1'b1, DUR_20, 1'b1);
                  5'd1, 5'd8, 5'd15:  e = make_entry(3'd1, 1'b1, DUR_20, 1'b1);
                  5'd2, 5'd9, 5'd16:  e = make_entry(3'd2, 1'b1, DUR_20, 1'b1);
                  5'd3, 5'd10, 5'd17: e = make_entry(3'd3, 1'b1, DUR_20, 1'b1);
                  5'd4, 5'd11, 5'd18: e = make_entry(3'd4, 1'b1, DUR_20, 1'b1);
                  5'd5, 5'd12, 5'd19: e = make_entry(3'd5, 1'b1, DUR_20, 1'b1);
                  5'd6, 5'd13, 5'd20: e = make_entry(3'd6, 1'b1, DUR_20, 1'b1);
                  default:            e = '0;
               endcase
            end
            2'd1: begin
               unique case (step[4:0])
                  5'd0:    e = make_entry(3'd0, 1'b1, DUR_10, 1'b0);
                  5'd1:    e = make_entry(3'd1, 1'b1, DUR_10, 1'b0);
                  5'd2:    e = make_entry(3'd2, 1'b1, DUR_10, 1'b0);
                  5'd3:    e = make_entry(3'd0, 1'b0, DUR_50, 1'b1);
                  5'd4:    e = make_entry(3'd3, 1'b1, DUR_10, 1'b0);
                  5'd5:    e = make_entry(3'd4, 1'b1, DUR_10, 1'b0);
                  5'd6:    e = make_entry(3'd5, 1'b1, DUR_10, 1'b0);
                  5'd7:    e = make_entry(3'd6, 1'b1, DUR_10, 1'b0);
                  5'd8:    e = make_entry(3'd0, 1'b0, DUR_50, 1'b1);
                  5'd9:    e = make_entry(3'd0, 1'b0, DUR_250, 1'b0);
                  5'd10:   e = make_entry(3'd0, 1'b0, DUR_LOOP, 1'b0);
                  default: e = '0;
               endcase
            end
            2'd2: begin
               unique case (step[4:0])
                  5'd0:    e = make_entry(3'd0, 1'b1, DUR_5, 1'b1);
                  5'd1:    e = make_entry(3'd1, 1'b1, DUR_5, 1'b1);
                  5'd2:    e = make_entry(3'd2, 1'b1, DUR_5, 1'b1);
                  5'd3:    e = make_entry(3'd3, 1'b1, DUR_5, 1'b1);
                  5'd4:    e = make_entry(3'd4, 1'b1, DUR_5, 1'b1);
                  5'd5:    e = make_entry(3'd5, 1'b1, DUR_5, 1'b1);
                  5'd6:    e = make_entry(3'd6, 1'b1, DUR_5, 1'b1);
                  default: e = '0;
               endcase
            end
            default: e = '0;
         endcase
      end
      return e;
   endfunction

endpackage

@@ rtl/lpsd_debounce.sv @@
// ----------------------------------------------------------------------------
// lpsd_debounce: equal-count input debouncer
// One counter per pin; a pin's clean level flips after enough differing samples.
// ----------------------------------------------------------------------------
module lpsd_debounce import lpsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      update,
   input  pins_type  raw,
   input  count_type debounce_ticks,
   output pins_type  clean_in,
   output pins_type  clean_ff
);

   count_type count_ff [INPUT_COUNT];
   count_type count_in [INPUT_COUNT];
   count_type count_inc [INPUT_COUNT];

   // per-pin counter and level update
   always_comb begin
      clean_in = clean_ff;
      for (int i = 0; i < INPUT_COUNT; i++) begin
         count_inc[i] = count_ff[i] + 8'd1;
         count_in[i]  = count_ff[i];
         if (update) begin
            if (raw[i] != clean_ff[i]) begin
               if (count_inc[i] == debounce_ticks) begin
                  clean_in[i] = raw[i];
                  count_in[i] = '0;
               end else begin
                  count_in[i] = count_inc[i];
               end
            end else begin
               count_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clean_ff <= '0;
         for (int i = 0; i < INPUT_COUNT; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         clean_ff <= clean_in;
         for (int i = 0; i < INPUT_COUNT; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   // clean levels only move on an update
   a_clean_hold: assert property (@(posedge clock) disable iff (reset)
      !update |=> $stable(clean_ff))
      else $error("clean levels changed without an update");

endmodule

@@ rtl/lpsd_player.sv @@
// ----------------------------------------------------------------------------
// lpsd_player: animation player and buzzer drive
// Walks the pattern table per update and toggles the buzzer pin per tick.
// ----------------------------------------------------------------------------
module lpsd_player import lpsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  player_ctl_type ctl,
   output led_type        led_in,
   output logic           buzzer_in,
   output logic           running_in
);

   sel_type       active_ff, active_in;
   count_type     pos_ff, pos_in;
   count_type     ticks_ff, ticks_in;
   logic          buz_en_ff, buz_en_in;
   logic          level_ff;
   led_type       led_ff;
   count_type     pos_next;
   rom_entry_type entry_next, entry_first, entry;
   logic          wraps;

   // table lookups for the next step and for a loop back to step zero
   assign pos_next    = pos_ff + 8'd1;
   assign entry_next  = rom_read(active_ff, pos_next);
   assign entry_first = rom_read(active_ff, 8'd0);
   assign wraps       = (entry_next.dur == DUR_LOOP);
   assign entry       = wraps ? entry_first : entry_next;

   // next player state
   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      ticks_in  = ticks_ff;
      buz_en_in = buz_en_ff;
      buzzer_in = level_ff;
      led_in    = led_ff;
      if (ctl.start) begin
         active_in = pattern_valid(ctl.sel) ? ctl.sel : NO_PATTERN;
         pos_in    = DUR_LOOP;
         ticks_in  = '0;
         if (!pattern_valid(ctl.sel)) begin
            buz_en_in = 1'b0;
            led_in    = '0;
         end
      end else if (ctl.tick) begin
         buzzer_in = buz_en_ff & ~level_ff;
         if (ctl.update && pattern_valid(active_ff)) begin
            if (ticks_ff != 8'd0) begin
               ticks_in = ticks_ff - 8'd1;
            end else begin
               pos_in = wraps ? 8'd0 : pos_next;
               if (entry.dur == DUR_END) begin
                  active_in = NO_PATTERN;
               end else begin
                  ticks_in = entry.dur - 8'd1;
               end
               buz_en_in = entry.buz;
               led_in    = entry.mask;
            end
         end
      end
      running_in = pattern_valid(active_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= NO_PATTERN;
         pos_ff    <= DUR_LOOP;
         ticks_ff  <= '0;
         buz_en_ff <= 1'b0;
         level_ff  <= 1'b0;
         led_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         ticks_ff  <= ticks_in;
         buz_en_ff <= buz_en_in;
         level_ff  <= buzzer_in;
         led_ff    <= led_in;
      end
   end

   // starting no pattern clears the LEDs and the buzzer enable
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (ctl.start && !pattern_valid(ctl.sel)) |=> (led_ff == '0 && !buz_en_ff))
      else $error("stop did not clear the outputs");

   // a tick with the buzzer disabled leaves the pin low
   a_buzzer_low: assert property (@(posedge clock) disable iff (reset)
      (ctl.tick && !ctl.start && !buz_en_ff) |=> !level_ff)
      else $error("buzzer pin high while disabled");

endmodule

@@ rtl/led_pattern_sequencer_debounce.sv @@
// ----------------------------------------------------------------------------
// led_pattern_sequencer_debounce: LED pattern sequencer with input debounce
// Input register, prescaler, debouncer, player and result register.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then its result is
// loaded into the result register, where it waits until it is taken.
// Throughput: one item per cycle, since all work for an item fits the single
// logic stage between the two registers; a held result stalls the input.
// Reset (synchronous, active high) empties both stages, loads the register
// defaults and stops any animation; no start-up delay follows.
module led_pattern_sequencer_debounce import lpsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] raw_inputs, [4:3] animation_select
   input  logic        req_tuser,   // [0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [19:0] led_levels, [20] buzzer_pin,
                                    // [23:21] clean_inputs, [24] pattern_running
   // configuration port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic           in_valid_ff;
   logic           in_cmd_ff;
   pins_type       in_raw_ff;
   sel_type        in_sel_ff;
   logic           advance;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_data_ff;
   count_type      tick_prescale_ff, debounce_ticks_ff;
   count_type      prescale_ff, prescale_in;
   logic           is_tick, do_update;
   player_ctl_type ctl;
   pins_type       clean_in, clean_ff;
   led_type        led_in;
   logic           buzzer_in, running_in;

   // handshake: the input register refills whenever it drains
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_prescale_ff  <= TICK_PRESCALE_RESET;
         debounce_ticks_ff <= DEBOUNCE_TICKS_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_TICK_PRESCALE) begin
            tick_prescale_ff <= csr_wdata;
         end else if (csr_index == CSR_DEBOUNCE_TICKS) begin
            debounce_ticks_ff <= csr_wdata;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff <= req_tuser;
         in_raw_ff <= req_tdata[2:0];
         in_sel_ff <= req_tdata[4:3];
      end
   end

   // prescaler: an update fires when the count runs down to zero
   assign is_tick   = advance && (in_cmd_ff == CMD_TICK);
   assign do_update = is_tick && (prescale_ff == 8'd1);

   always_comb begin
      prescale_in = prescale_ff;
      if (is_tick) begin
         prescale_in = do_update ? tick_prescale_ff : prescale_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= TICK_PRESCALE_RESET;
      end else begin
         prescale_ff <= prescale_in;
      end
   end

   lpsd_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .update         (do_update),
      .raw            (in_raw_ff),
      .debounce_ticks (debounce_ticks_ff),
      .clean_in       (clean_in),
      .clean_ff       (clean_ff)
   );

   assign ctl.tick   = is_tick;
   assign ctl.start  = advance && (in_cmd_ff == CMD_START);
   assign ctl.update = do_update;
   assign ctl.sel    = in_sel_ff;

   lpsd_player u_player (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .led_in     (led_in),
      .buzzer_in  (buzzer_in),
      .running_in (running_in)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {7'd0, running_in, clean_in, buzzer_in, led_in};
      end
   end

   // every item that leaves the input register shows up as a result
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("item lost between stages");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for led_pattern_sequencer_debounce
// Drives tick and start items with random gaps and back-pressure, predicts
// LEDs, buzzer pin, debounced inputs and running flag per item, and compares
// every result in order. Several prescale and debounce settings are visited,
// extremes included, with writes only while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
   import lpsd_pkg::*;

   localparam int         CYCLE_LIMIT      = 200_000;
   localparam int         LONG_HOLD        = 400;
   localparam int         LONG_HOLD_AT     = 300;
   localparam int         REPORT_LIMIT     = 100;
   localparam logic [7:0] CSR_INDEX_UNUSED = 8'd2;

   // animation selectors
   localparam sel_type PATTERN_CHASE = 2'd0;
   localparam sel_type PATTERN_BLINK = 2'd1;
   localparam sel_type PATTERN_SWEEP = 2'd2;

   // one result item, packed as on rsp_tdata[24:0]
   typedef struct packed {
      logic     running;
      pins_type clean;
      logic     buzzer;
      led_type  leds;
   } panel_type;

   // predicts the panel after each accepted item and checks results in order
   class sequencer_scoreboard;
      count_type prescale_reload;
      count_type debounce_limit;
      count_type prescale_left;
      count_type settle_count [INPUT_COUNT];
      pins_type  clean;
      sel_type   playing;
      count_type step_at;
      count_type hold_left;
      logic      buzz_on;
      logic      buzz_pin;
      led_type   leds;
      panel_type expected_panels [$];
      int        errors;

      function new();
         prescale_reload = TICK_PRESCALE_RESET;
         debounce_limit  = DEBOUNCE_TICKS_RESET;
         prescale_left   = TICK_PRESCALE_RESET;
         foreach (settle_count[i]) settle_count[i] = '0;
         clean     = '0;
         playing   = NO_PATTERN;
         step_at   = 8'hFF;
         hold_left = '0;
         buzz_on   = 1'b0;
         buzz_pin  = 1'b0;
         leds      = '0;
         errors    = 0;
      endfunction

      // three adjacent leds per group, the last group holds the top two
      function led_type group_leds(int g);
         return (g == 6) ? led_type'(20'hC_0000) : led_type'(20'h7 << (3 * g));
      endfunction

      // animation table; anything outside a pattern is an end entry
      function rom_entry_type step_entry(sel_type p, count_type s);
         rom_entry_type e;
         int            si;
         e  = '0;
         si = int'(s);
         if (si < MAX_STEPS) begin
            case (p)
               PATTERN_CHASE: begin
                  if (si < 21) begin
                     e.mask = group_leds(si % 7);
                     e.dur  = 8'(20 / TICK_MS);
                     e.buz  = 1'b1;
                  end
               end
               PATTERN_BLINK: begin
                  if (si < 3 || (si >= 4 && si < 8)) begin
                     e.mask = group_leds(si < 3 ? si : si - 1);
                     e.dur  = 8'(10 / TICK_MS);
                  end else if (si == 3 || si == 8) begin
                     e.dur = 8'(50 / TICK_MS);
                     e.buz = 1'b1;
                  end else if (si == 9) begin
                     e.dur = 8'(250 / TICK_MS);
                  end else if (si == 10) begin
                     e.dur = DUR_LOOP;
                  end
               end
               PATTERN_SWEEP: begin
                  if (si < 7) begin
                     e.mask = group_leds(si);
                     e.dur  = 8'(5 / TICK_MS);
                     e.buz  = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         return e;
      endfunction

      function void note_config(logic [7:0] index, logic [7:0] value);
         case (index)
            CSR_TICK_PRESCALE:  prescale_reload = value;
            CSR_DEBOUNCE_TICKS: debounce_limit  = value;
            default: ;
         endcase
      endfunction

      function void note_item(logic cmd, pins_type raw, sel_type sel);
         rom_entry_type e;
         panel_type     p;
         if (cmd == CMD_START) begin
            // start: restart before the first step, no tick
            playing   = (32'(sel) < PATTERN_COUNT) ? sel : NO_PATTERN;
            step_at   = 8'hFF;
            hold_left = '0;
            if (playing == NO_PATTERN) begin
               buzz_on = 1'b0;
               leds    = '0;
            end
         end else begin
            buzz_pin      = buzz_on ? !buzz_pin : 1'b0;
            prescale_left = prescale_left - 8'd1;
            if (prescale_left == '0) begin
               prescale_left = prescale_reload;
               // equal-count debounce per pin
               for (int i = 0; i < INPUT_COUNT; i++) begin
                  if (raw[i] != clean[i]) begin
                     settle_count[i] = settle_count[i] + 8'd1;
                     if (settle_count[i] == debounce_limit) begin
                        clean[i]        = raw[i];
                        settle_count[i] = '0;
                     end
                  end else begin
                     settle_count[i] = '0;
                  end
               end
               // animation update
               if (32'(playing) < PATTERN_COUNT) begin
                  if (hold_left != '0) begin
                     hold_left = hold_left - 8'd1;
                  end else begin
                     step_at = step_at + 8'd1;
                     e       = step_entry(playing, step_at);
                     if (e.dur == DUR_LOOP) begin
                        step_at = '0;
                        e       = step_entry(playing, step_at);
                     end
                     if (e.dur == DUR_END) playing = NO_PATTERN;
                     else hold_left = e.dur - 8'd1;
                     buzz_on = e.buz;
                     leds    = e.mask;
                  end
               end
            end
         end
         p.leds    = leds;
         p.buzzer  = buzz_pin;
         p.clean   = clean;
         p.running = 32'(playing) < PATTERN_COUNT;
         expected_panels.push_back(p);
      endfunction

      function void check_result(logic [31:0] data);
         panel_type got;
         panel_type want;
         got = data[24:0];
         if (expected_panels.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) $error("result with nothing expected: %h", data);
            return;
         end
         want = expected_panels.pop_front();
         if (got.leds !== want.leds) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $error("led_levels: expected %h, actual %h", want.leds, got.leds);
         end
         if (got.buzzer !== want.buzzer) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $error("buzzer_pin: expected %b, actual %b", want.buzzer, got.buzzer);
         end
         if (got.clean !== want.clean) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $error("clean_inputs: expected %b, actual %b", want.clean, got.clean);
         end
         if (got.running !== want.running) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $error("pattern_running: expected %b, actual %b", want.running, got.running);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [2:0] raw_inputs, [4:3] animation_select
   logic        req_tuser  = 1'b0; // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [19:0] led_levels, [20] buzzer_pin,
                                   // [23:21] clean_inputs, [24] pattern_running
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index  = '0;
   logic [7:0]  csr_wdata  = '0;
   logic        tx_burst   = 1'b0;
   logic        rx_burst   = 1'b0;
   int          cycle_count;

   sequencer_scoreboard sb = new();

   led_pattern_sequencer_debounce u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic cmd, input pins_type raw, input sel_type sel);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, sel, raw};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      sb.note_item(cmd, raw, sel);
   endtask

   // stop offering and wait for every expected result
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_panels.size() != 0) @(posedge clock);
   endtask

   // register writes, issued only while the block is drained
   task automatic configure(input count_type prescale, input count_type debounce,
                            input logic poke_unused);
      logic [7:0] idx [3];
      logic [7:0] val [3];
      int         count;
      idx[0] = CSR_TICK_PRESCALE;
      idx[1] = CSR_DEBOUNCE_TICKS;
      idx[2] = CSR_INDEX_UNUSED;
      val[0] = prescale;
      val[1] = debounce;
      val[2] = 8'($urandom);
      count  = poke_unused ? 3 : 2;
      for (int i = 0; i < count; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         do @(posedge clock); while (!csr_ready);
         sb.note_config(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // random ticks with held input levels, glitches and occasional starts
   task automatic run_random(input int items, input int change_odds);
      pins_type level;
      pins_type raw;
      level = 3'($urandom);
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
         if ($urandom_range(0, change_odds - 1) == 0) level = 3'($urandom);
         raw = level;
         if (change_odds < 100 && $urandom_range(0, 19) == 0) raw = 3'($urandom);
         if ($urandom_range(0, 59) == 0)
            send_item(CMD_START, raw, sel_type'($urandom_range(0, 3)));
         else
            send_item(CMD_TICK, raw, sel_type'($urandom));
      end
   endtask

   // result side: random stalls, one long hold-off to fill the block
   initial begin
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 15);
         if (taken == LONG_HOLD_AT) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
         taken++;
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("led_pattern_sequencer_debounce test failed");
      $finish;
   end

   // stimulus
   initial begin
      count_type prescales [7];
      count_type debounces [7];
      int        lengths   [7];
      int        odds      [7];
      prescales = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd1, 8'd3, 8'd5};
      debounces = '{8'd1, 8'd3, 8'd255, 8'd0, 8'd255, 8'd1, 8'd4};
      lengths   = '{180, 180, 60, 260, 280, 120, 100};
      odds      = '{6, 10, 50, 400, 2000, 4, 8};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: every pattern, stop, and extreme input levels at reset settings
      send_item(CMD_TICK, 3'b000, PATTERN_CHASE);
      send_item(CMD_START, 3'b111, PATTERN_CHASE);
      repeat (10) send_item(CMD_TICK, 3'b111, NO_PATTERN);
      send_item(CMD_START, 3'b000, PATTERN_BLINK);
      repeat (4) send_item(CMD_TICK, 3'b101, NO_PATTERN);
      send_item(CMD_START, 3'b010, PATTERN_SWEEP);
      repeat (4) send_item(CMD_TICK, 3'b000, PATTERN_SWEEP);
      send_item(CMD_START, 3'b111, NO_PATTERN);
      send_item(CMD_TICK, 3'b111, PATTERN_BLINK);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 7; ph++) begin
         configure(prescales[ph], debounces[ph], ph == 2);
         run_random(lengths[ph], odds[ph]);
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_panels.size() == 0)
         $display("led_pattern_sequencer_debounce test passed");
      else
         $display("led_pattern_sequencer_debounce test failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/lpsd_pkg.sv
rtl/lpsd_debounce.sv
rtl/lpsd_player.sv
rtl/led_pattern_sequencer_debounce.sv
dv/tb_top.sv
